FILE: rtl/mbe_pkg.sv
package mbe_pkg;

  localparam int CoordW = 32;
  localparam int ProdW  = 64;
  localparam int WideW  = 66;
  localparam int PixW   = 12;
  localparam int CountW = 16;
  localparam int CfgIdxW = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [WideW-1:0]  wide_t;
  typedef logic [PixW-1:0]          pix_t;
  typedef logic [CfgIdxW-1:0]       cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t RegMaxIter  = 3'd0;
  localparam cfg_idx_t RegLeftEdge = 3'd1;
  localparam cfg_idx_t RegLowEdge  = 3'd2;
  localparam cfg_idx_t RegXStep    = 3'd3;
  localparam cfg_idx_t RegYStep    = 3'd4;

  localparam coord_t CoordMax = 32'sh7FFF_FFFF;
  localparam coord_t CoordMin = 32'sh8000_0000;

  // Clamp a wide signed value to the coordinate range
  function automatic coord_t sat_coord(wide_t v);
    coord_t r;
    if (v > wide_t'(CoordMax)) begin
      r = CoordMax;
    end else if (v < wide_t'(CoordMin)) begin
      r = CoordMin;
    end else begin
      r = coord_t'(v);
    end
    return r;
  endfunction

endpackage

FILE: rtl/mbe_mul.sv
module mbe_mul import mbe_pkg::*; (
  input  logic   clk_i,
  input  coord_t a_i,
  input  coord_t b_i,
  output prod_t  p_o
);

  prod_t p_q;

  // Exact signed product, registered
  always_ff @(posedge clk_i) begin
    p_q <= prod_t'(a_i) * prod_t'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: rtl/mandelbrot_escape_time.sv
// Channel   Direction  Signals                               Handshake
// cfg       in         cfg_index_i, cfg_data_i               cfg_we_i (no wait)
// pixel     in         pixel_column_i, pixel_row_i           in_valid_i / in_ready_o
// result    out        escape_count_o                        out_valid_o / out_ready_i
//
// Sequencing: one shared 32x32 multiplier forms x*x, y*y and x*y in turn, then
// ST_UPD applies the saturating update; the point c is formed in the ST_PT_RE,
// ST_PT_IM and ST_PT_END steps.
// Reset (rst_ni, async low) restores the register defaults and empties the block.
// in_ready_o is high only while idle; a finished result waits in the output
// register, so a new pixel may be accepted while the result is still stalled.
module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  cfg_idx_t        cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [PixW-1:0] pixel_column_i,
  input  logic [PixW-1:0] pixel_row_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CountW-1:0] escape_count_o
);

  typedef logic [COUNT_BITS-1:0] cnt_t;

  // Largest count the counter holds, and the escape threshold |z|^2 >= 4
  localparam logic [32:0] CntMax = (33'd1 << COUNT_BITS) - 33'd1;
  localparam logic [64:0] EscThr = 65'd1 << (FRAC_BITS + 2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PT_RE,
    ST_PT_IM,
    ST_PT_END,
    ST_SQ_X,
    ST_SQ_Y,
    ST_XY,
    ST_UPD,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [15:0] max_iter_q;
  coord_t      left_q, lower_q, xstep_q, ystep_q;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [CountW-1:0] count_q, count_d;

  // Datapath registers
  pix_t   col_q, col_d, row_q, row_d;
  cnt_t   limit_q, limit_d, n_q, n_d;
  coord_t cre_q, cre_d, cim_q, cim_d;
  coord_t x_q, x_d, y_q, y_d;
  prod_t  xx_q, xx_d, yy_q, yy_d;

  // Shared multiplier
  coord_t mul_a, mul_b;
  prod_t  mul_p;

  mbe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  logic        in_fire;
  logic [63:0] mag;
  logic        escaped;
  wide_t       re_wide, im_wide;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Route operands to the multiplier by sequencer step
  always_comb begin
    case (state_q)
      ST_PT_RE: begin
        mul_a = $signed({20'd0, col_q});
        mul_b = xstep_q;
      end
      ST_PT_IM: begin
        mul_a = $signed({20'd0, row_q});
        mul_b = ystep_q;
      end
      ST_SQ_X: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      ST_SQ_Y: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = y_q;
      end
    endcase
  end

  // |z|^2 of the current point: x*x held, y*y just out of the multiplier
  assign mag     = $unsigned(xx_q) + $unsigned(mul_p);
  assign escaped = (({1'b0, mag}) >> FRAC_BITS) >= EscThr;

  // Next z: floor-shifted products plus c
  assign re_wide = ((wide_t'(xx_q) - wide_t'(yy_q)) >>> FRAC_BITS) + wide_t'(cre_q);
  assign im_wide = (wide_t'(mul_p) >>> (FRAC_BITS - 1)) + wide_t'(cim_q);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    col_d       = col_q;
    row_d       = row_q;
    limit_d     = limit_q;
    n_d         = n_q;
    cre_d       = cre_q;
    cim_d       = cim_q;
    x_d         = x_q;
    y_d         = y_q;
    xx_d        = xx_q;
    yy_d        = yy_q;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // Clamp pixels outside the image to the last column or row
          col_d = ({20'd0, pixel_column_i} >= 32'(MAX_WIDTH)) ?
                  pix_t'(MAX_WIDTH - 1) : pixel_column_i;
          row_d = ({20'd0, pixel_row_i} >= 32'(MAX_HEIGHT)) ?
                  pix_t'(MAX_HEIGHT - 1) : pixel_row_i;
          limit_d = ({17'd0, max_iter_q} > CntMax) ? cnt_t'(CntMax) : cnt_t'(max_iter_q);
          n_d   = '0;
          x_d   = '0;
          y_d   = '0;
          state_d = ST_PT_RE;
        end
      end
      ST_PT_RE: state_d = ST_PT_IM;
      ST_PT_IM: begin
        cre_d   = sat_coord(wide_t'(mul_p) + wide_t'(left_q));
        state_d = ST_PT_END;
      end
      ST_PT_END: begin
        cim_d   = sat_coord(wide_t'(mul_p) + wide_t'(lower_q));
        state_d = ST_SQ_X;
      end
      ST_SQ_X: state_d = ST_SQ_Y;
      ST_SQ_Y: begin
        xx_d    = mul_p;
        state_d = ST_XY;
      end
      ST_XY: begin
        yy_d = mul_p;
        // Stop on escape of the last step, or at the limit
        if (escaped || (n_q == limit_q)) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        x_d     = sat_coord(re_wide);
        y_d     = sat_coord(im_wide);
        n_d     = n_q + cnt_t'(1);
        state_d = ST_SQ_X;
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          count_d     = CountW'(n_q);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      max_iter_q  <= 16'd256;
      left_q      <= 32'shE000_0000;
      lower_q     <= 32'shE000_0000;
      xstep_q     <= 32'sh0010_0000;
      ystep_q     <= 32'sh0010_0000;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMaxIter:  max_iter_q <= cfg_data_i[15:0];
          RegLeftEdge: left_q     <= $signed(cfg_data_i);
          RegLowEdge:  lower_q    <= $signed(cfg_data_i);
          RegXStep:    xstep_q    <= $signed(cfg_data_i);
          RegYStep:    ystep_q    <= $signed(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    row_q   <= row_d;
    limit_q <= limit_d;
    n_q     <= n_d;
    cre_q   <= cre_d;
    cim_q   <= cim_d;
    x_q     <= x_d;
    y_q     <= y_d;
    xx_q    <= xx_d;
    yy_q    <= yy_d;
  end

  assign out_valid_o    = out_valid_q;
  assign escape_count_o = count_q;

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  // Fixed-point format and run shape
  localparam int FracBits        = 28;
  localparam int QOneI           = 1 << FracBits;      // 1.0 in Q4.28
  localparam int RandomWindows   = 9;
  localparam int PixelsPerWindow = 50;
  localparam int PixelsPlanned   = 18 + RandomWindows * PixelsPerWindow;
  localparam int QuietLimit      = 1_000_000;          // covers one 65535-iteration pixel
  localparam int TailCycles      = 20;

  localparam coord_t QUlp = 32'sh0000_0001;
  localparam coord_t QTwo = 32'sh2000_0000;

  // One pixel request; hold_back makes the driver wait for an empty pipeline first
  typedef struct packed {
    pix_t col;
    pix_t row;
    logic hold_back;
  } pixel_req_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  cfg_idx_t          cfg_index_i    = '0;
  logic [31:0]       cfg_data_i     = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  pix_t              pixel_column_i = '0;
  pix_t              pixel_row_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [CountW-1:0] escape_count_o;

  // Shadow copy of the configuration registers, reset values included
  logic [CountW-1:0] iter_limit = 16'd256;
  coord_t            re_origin  = 32'shE000_0000;
  coord_t            im_origin  = 32'shE000_0000;
  coord_t            re_pitch   = 32'sh0010_0000;
  coord_t            im_pitch   = 32'sh0010_0000;

  pixel_req_t        pixel_queue[$];
  logic [CountW-1:0] count_due[$];
  logic              pix_fire     = 1'b0;
  int                pixels_taken = 0;
  int                results_seen = 0;
  int                windows_set  = 0;
  int                failures     = 0;
  int                quiet_cycles = 0;

  mandelbrot_escape_time #(
    .MAX_WIDTH (4096),
    .MAX_HEIGHT(4096),
    .FRAC_BITS (FracBits),
    .COUNT_BITS(CountW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_column_i(pixel_column_i),
    .pixel_row_i   (pixel_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .escape_count_o(escape_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Clamp an exact sum to the signed 32-bit coordinate range
  function automatic longint clamp_coord(longint v);
    if (v > longint'(CoordMax)) begin
      return longint'(CoordMax);
    end else if (v < longint'(CoordMin)) begin
      return longint'(CoordMin);
    end
    return v;
  endfunction

  // Iterate z = z^2 + c for one pixel under the current window and return the count
  function automatic logic [CountW-1:0] escape_count_of(pix_t col, pix_t row);
    longint            c_re, c_im, zr, zi, rr, ii, ri, zr_next, zi_next;
    longint unsigned   mag;
    int unsigned       n;
    bit                escaped;
    c_re    = clamp_coord(longint'(col) * longint'(re_pitch) + longint'(re_origin));
    c_im    = clamp_coord(longint'(row) * longint'(im_pitch) + longint'(im_origin));
    zr      = 0;
    zi      = 0;
    n       = 0;
    escaped = 1'b0;
    while (n < iter_limit && !escaped) begin
      rr      = zr * zr;
      ii      = zi * zi;
      ri      = zr * zi;
      // Arithmetic shifts floor; the cross term shifts one less to double it
      zr_next = clamp_coord(((rr - ii) >>> FracBits) + c_re);
      zi_next = clamp_coord((ri >>> (FracBits - 1)) + c_im);
      zr      = zr_next;
      zi      = zi_next;
      // Escape on the exact magnitude, no rounding
      mag     = longint'(zr * zr) + longint'(zi * zi);
      escaped = (mag >> FracBits) >= (64'd4 << FracBits);
      n++;
    end
    return CountW'(n);
  endfunction

  // Write one register over the plain write port and mirror its effect
  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      RegMaxIter:  iter_limit = value[CountW-1:0];
      RegLeftEdge: re_origin  = coord_t'(value);
      RegLowEdge:  im_origin  = coord_t'(value);
      RegXStep:    re_pitch   = coord_t'(value);
      RegYStep:    im_pitch   = coord_t'(value);
      default: ;  // drop writes to unmapped indexes
    endcase
  endtask

  task automatic set_window(logic [CountW-1:0] lim, coord_t re0, coord_t im0,
                            coord_t dre, coord_t dim);
    write_reg(RegMaxIter, 32'(lim));
    write_reg(RegLeftEdge, re0);
    write_reg(RegLowEdge, im0);
    write_reg(RegXStep, dre);
    write_reg(RegYStep, dim);
    windows_set++;
  endtask

  // Hit every index above the mapped ones; the block must ignore them
  task automatic poke_unmapped();
    for (int k = int'(RegYStep) + 1; k < (1 << CfgIdxW); k++) begin
      write_reg(cfg_idx_t'(k), $urandom());
    end
  endtask

  // Mostly windows over the interesting part of the plane, sometimes raw noise
  task automatic pick_random_window();
    logic [CountW-1:0] lim;
    coord_t            re0, im0, dre, dim;
    if ($urandom_range(0, 3) == 0) begin
      lim = CountW'($urandom_range(0, 60));
      re0 = coord_t'($urandom());
      im0 = coord_t'($urandom());
      dre = coord_t'($urandom());
      dim = coord_t'($urandom());
    end else begin
      lim = ($urandom_range(0, 9) == 0) ? '0 : CountW'($urandom_range(1, 160));
      re0 = coord_t'(-(5 * QOneI) / 2 + int'($urandom_range(0, QOneI)));
      dre = coord_t'($urandom_range(65536, 196608));
      if ($urandom_range(0, 1) == 1) begin
        im0 = coord_t'(-(3 * QOneI) / 2 + int'($urandom_range(0, QOneI / 2)));
        dim = coord_t'($urandom_range(32768, 98304));
      end else begin
        im0 = coord_t'(QOneI + int'($urandom_range(0, QOneI / 2)));
        dim = -coord_t'($urandom_range(32768, 98304));
      end
    end
    set_window(lim, re0, im0, dre, dim);
  endtask

  task automatic queue_pixel(pix_t col, pix_t row, logic hold_back);
    pixel_req_t req;
    req.col       = col;
    req.row       = row;
    req.hold_back = hold_back;
    pixel_queue.push_back(req);
  endtask

  // Block until the pipeline is empty: nothing pending, nothing offered, nothing owed
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pixel_queue.size() != 0 || in_valid_i || count_due.size() != 0);
  endtask

  // Driver: present pixels at the falling edge, hold them until the transaction
  // completes. Idle mix follows progress: sender-light, then receiver-light, then none.
  always @(negedge clk_i) begin : drive_pixels
    int         stage;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         fresh;
    pixel_req_t req;
    stage         = (pixels_taken * 3) / PixelsPlanned;
    send_idle_pct = (stage == 0) ? 26 : (stage == 1) ? 52 : 0;
    recv_idle_pct = (stage == 0) ? 52 : (stage == 1) ? 26 : 0;
    if (rst_ni) begin
      // Advance only when the offered pixel went through or nothing is offered
      if (!in_valid_i || pix_fire) begin
        fresh = pixel_queue.size() != 0 &&
                !(pixel_queue[0].hold_back && count_due.size() != 0) &&
                $urandom_range(0, 99) >= send_idle_pct;
        if (fresh) begin
          req = pixel_queue.pop_front();
          pixel_column_i <= req.col;
          pixel_row_i    <= req.row;
        end
        in_valid_i <= fresh;
      end
      out_ready_i <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // Monitor: predict at input transactions, check at result transactions
  always @(posedge clk_i) begin : check_counts
    logic [CountW-1:0] want;
    if (rst_ni) begin
      pix_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        count_due.push_back(escape_count_of(pixel_column_i, pixel_row_i));
        pixels_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (count_due.size() == 0) begin
          $error("escape_count: expected no result, actual %0d", escape_count_o);
          failures++;
        end else begin
          want = count_due.pop_front();
          if (escape_count_o !== want) begin
            $error("escape_count: expected %0d, actual %0d", want, escape_count_o);
            failures++;
          end
        end
      end
    end
  end

  // Watchdog: end the run after too long without any transaction
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $error("no transaction for %0d cycles, %0d results still owed", QuietLimit,
             count_due.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset window: corner pixels, alternating bit patterns, and the origin,
    // which never escapes and runs into the default limit
    queue_pixel(12'd0, 12'd0, 1'b0);
    queue_pixel(12'd512, 12'd512, 1'b0);
    queue_pixel(12'hFFF, 12'hFFF, 1'b0);
    queue_pixel(12'hAAA, 12'h555, 1'b1);
    queue_pixel(12'h555, 12'hAAA, 1'b0);
    queue_pixel(12'd2048, 12'd2048, 1'b0);
    wait_quiet();

    // Zero limit: every pixel returns zero
    set_window('0, coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
               coord_t'($urandom()));
    queue_pixel(12'd0, 12'd0, 1'b0);
    queue_pixel(12'hFFF, 12'hFFF, 1'b0);
    wait_quiet();

    // Full-scale limit and extreme coordinates: both point sums saturate; pixel
    // (1,1) lands one step left of and below the origin and runs all 65535 iterations
    set_window(16'hFFFF, CoordMin, CoordMax, CoordMax, CoordMin);
    queue_pixel(12'd0, 12'd0, 1'b0);
    queue_pixel(12'hFFF, 12'hFFF, 1'b0);
    queue_pixel(12'd0, 12'hFFF, 1'b0);
    queue_pixel(12'd1, 12'd1, 1'b0);
    wait_quiet();

    // Left tip of the set: c = -2 hits |z|^2 = 4 exactly, one step right stays bounded
    set_window(16'd100, -QTwo, '0, QUlp, QTwo);
    queue_pixel(12'd0, 12'd0, 1'b0);
    queue_pixel(12'd1, 12'd0, 1'b0);
    queue_pixel(12'd0, 12'd1, 1'b0);
    wait_quiet();

    // Right side: c = 2 escapes at once, one step left needs a second pass;
    // writes to unmapped indexes in between must leave the window alone
    set_window(16'd100, QTwo, '0, -QUlp, QUlp);
    poke_unmapped();
    queue_pixel(12'd0, 12'd0, 1'b0);
    queue_pixel(12'd1, 12'd0, 1'b1);
    queue_pixel(12'd0, 12'd1, 1'b0);
    wait_quiet();

    // Random windows, random pixels; now and then drain before the next pixel
    for (int w = 0; w < RandomWindows; w++) begin
      pick_random_window();
      if (w == RandomWindows / 2) begin
        poke_unmapped();
      end
      for (int p = 0; p < PixelsPerWindow; p++) begin
        queue_pixel(pix_t'($urandom_range(0, 4095)), pix_t'($urandom_range(0, 4095)),
                    $urandom_range(0, 39) == 0);
      end
      wait_quiet();
    end

    // Let any stray result show up before closing
    repeat (TailCycles) @(posedge clk_i);
    if (count_due.size() != 0) begin
      $error("escape_count: %0d expected results never arrived", count_due.size());
      failures++;
    end

    $display("Ran %0d pixels through %0d windows, %0d counts checked.", pixels_taken,
             windows_set, results_seen);
    $display("Limits from zero to full scale, saturated points, exact escape boundary.");
    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mbe_pkg.sv
rtl/mbe_mul.sv
rtl/mandelbrot_escape_time.sv
sim/tb_top.sv
